// ===== src/rmu_pkg.sv =====
// ----------------------------------------------------------------------------
// rmu_pkg: shared definitions for the cluster run ring merge unit
// Field widths, the ring size register format and the write command that
// the top level sends to each ring cell.
// ----------------------------------------------------------------------------
package rmu_pkg;

    // Width of a cluster number and of a flag word.
    localparam int FIELD_W = 32;

    // Width of the ring size register and of the entry count.
    localparam int CNT_W = 5;

    // Width of the slot field on the result beat.
    localparam int SLOT_W = 4;

    // Default number of ring cells.
    localparam int RING_DEPTH_DEF = 16;

    // Ring size after reset.
    localparam int RING_SIZE_RST = 16;

    // Largest value the ring size register can hold.
    localparam int SIZE_MAX = (1 << CNT_W) - 1;

    // Write command for one ring cell.
    typedef struct packed {
        logic take_merge;   // this cell absorbs the offered run
        logic append;       // this cell is loaded with the offered run
    } rmu_wr_t;

endpackage

// ===== src/rmu_cell.sv =====
// ----------------------------------------------------------------------------
// rmu_cell: one entry of the run ring
// Holds a stored run, checks it against the offered run for adjacency and
// reports its age rank so the picker can find the oldest match.
// ----------------------------------------------------------------------------
module rmu_cell
    import rmu_pkg::*;
#(
    parameter int CELL_ID = 0,
    parameter int IDX_W   = 4,
    parameter int CMP_W   = 6
)
(
    input  logic               clk,
    input  logic [CNT_W-1:0]   size,
    input  logic [IDX_W-1:0]   head,
    input  logic [CNT_W-1:0]   count,
    input  logic [FIELD_W-1:0] range_first,
    input  logic [FIELD_W-1:0] range_last,
    input  logic [FIELD_W-1:0] entry_flags,
    input  logic               merge_on,
    input  rmu_wr_t            wr,
    output logic               take,
    output logic [CMP_W-1:0]   rank
);

    localparam logic [CMP_W-1:0] MY_POS = CMP_W'(CELL_ID);

    logic [FIELD_W-1:0] first_reg;
    logic [FIELD_W-1:0] last_reg;
    logic [FIELD_W-1:0] flags_reg;

    logic [CMP_W-1:0] head_w;
    logic [CMP_W-1:0] size_w;
    logic [CMP_W-1:0] count_w;
    logic             live;
    logic             hit_front;
    logic             hit_back;

    // Age rank of this cell counted from the head of the ring.
    always_comb
    begin
        head_w  = CMP_W'(head);
        size_w  = CMP_W'(size);
        count_w = CMP_W'(count);
        if (MY_POS >= head_w)
        begin
            rank = MY_POS - head_w;
        end
        else
        begin
            rank = MY_POS + size_w - head_w;
        end
        live = (MY_POS < size_w) && (rank < count_w);
    end

    // Adjacency tests: the stored run follows or precedes the offered run.
    assign hit_front = (first_reg == (range_last + FIELD_W'(1)));
    assign hit_back  = ((last_reg + FIELD_W'(1)) == range_first);
    assign take      = merge_on && live && (hit_front || hit_back);

    // Entry storage. A merge keeps the stored flags.
    always_ff @(posedge clk)
    begin
        if (wr.append)
        begin
            first_reg <= range_first;
            last_reg  <= range_last;
            flags_reg <= entry_flags;
        end
        else if (wr.take_merge)
        begin
            if (hit_front)
            begin
                first_reg <= range_first;
            end
            else
            begin
                last_reg <= range_last;
            end
        end
    end

endmodule

// ===== src/rmu_pick.sv =====
// ----------------------------------------------------------------------------
// rmu_pick: oldest-match picker
// A balanced tree of compare-select nodes that returns the matching cell
// with the lowest age rank.
// ----------------------------------------------------------------------------
module rmu_pick
    import rmu_pkg::*;
#(
    parameter int N     = 16,
    parameter int IDX_W = 4,
    parameter int CMP_W = 6
)
(
    input  logic [N-1:0]     take,
    input  logic [CMP_W-1:0] rank [N],
    output logic             found,
    output logic [IDX_W-1:0] win_idx
);

    localparam int LEAVES = 1 << IDX_W;
    localparam int NODES  = 2 * LEAVES - 1;

    logic             node_take [NODES];
    logic [CMP_W-1:0] node_rank [NODES];
    logic [IDX_W-1:0] node_idx  [NODES];

    genvar g;

    // Leaves: one per cell, padding leaves never match.
    generate
        for (g = 0; g < LEAVES; g++)
        begin : g_leaf
            if (g < N)
            begin : g_used
                assign node_take[LEAVES - 1 + g] = take[g];
                assign node_rank[LEAVES - 1 + g] = rank[g];
            end
            else
            begin : g_pad
                assign node_take[LEAVES - 1 + g] = 1'b0;
                assign node_rank[LEAVES - 1 + g] = '0;
            end
            assign node_idx[LEAVES - 1 + g] = IDX_W'(g);
        end
    endgenerate

    // Inner nodes: keep the matching child with the lower rank.
    generate
        for (g = 0; g < LEAVES - 1; g++)
        begin : g_node
            logic pick_left;
            assign pick_left = node_take[2*g+1] &&
                               (!node_take[2*g+2] || (node_rank[2*g+1] <= node_rank[2*g+2]));
            assign node_take[g] = node_take[2*g+1] || node_take[2*g+2];
            assign node_rank[g] = pick_left ? node_rank[2*g+1] : node_rank[2*g+2];
            assign node_idx[g]  = pick_left ? node_idx[2*g+1]  : node_idx[2*g+2];
        end
    endgenerate

    assign found   = node_take[0];
    assign win_idx = node_idx[0];

endmodule

// ===== src/cluster_run_ring_merge_unit.sv =====
// ----------------------------------------------------------------------------
// cluster_run_ring_merge_unit: ring of cluster runs with adjacent merge
// Keeps up to ring_size runs; an offered run with merge_enable set merges
// into the oldest stored run that touches it, otherwise it is appended,
// overwriting the oldest entry when the ring is full.
// ----------------------------------------------------------------------------
// The unit takes one run per clock cycle and returns its result beat on the
// cycle after the run is accepted; a held result stalls the input only while
// out_stall is high. Each ring cell compares its stored run against the
// offered run in parallel, and a log2(RING_DEPTH)-level picker selects the
// oldest match, so the whole decision and the ring update settle in the
// accepting cycle. Writing ring_size empties the ring; stored runs need no
// clearing after reset, so the unit is ready on the first cycle out of reset.
module cluster_run_ring_merge_unit
    import rmu_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [CNT_W-1:0]   cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [FIELD_W-1:0] range_first,
    input  logic [FIELD_W-1:0] range_last,
    input  logic [FIELD_W-1:0] entry_flags,
    input  logic               merge_enable,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               merged,
    output logic [SLOT_W-1:0]  slot,
    output logic               overwrote_oldest,
    output logic [CNT_W-1:0]   entry_count
);

    localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CMP_W = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
    localparam int CAP   = (RING_DEPTH > SIZE_MAX) ? SIZE_MAX : RING_DEPTH;
    localparam int RST_SZ = (RING_DEPTH < RING_SIZE_RST) ? RING_DEPTH : RING_SIZE_RST;
    localparam logic [CNT_W-1:0] SIZE_CAP   = CNT_W'(CAP);
    localparam logic [CNT_W-1:0] SIZE_RESET = CNT_W'(RST_SZ);

    logic [CNT_W-1:0]  size_reg;
    logic [IDX_W-1:0]  head_reg;
    logic [IDX_W-1:0]  tail_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              out_valid_reg;
    logic              merged_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              overwrote_reg;
    logic [CNT_W-1:0]  count_out_reg;

    logic [CNT_W-1:0]  size_next;
    logic [IDX_W-1:0]  head_next;
    logic [IDX_W-1:0]  tail_next;
    logic [CNT_W-1:0]  count_next;
    logic [IDX_W-1:0]  slot_next;

    logic               accept;
    logic               full;
    logic               found;
    logic [IDX_W-1:0]   win_idx;
    logic [IDX_W-1:0]   app_idx;
    logic [RING_DEPTH-1:0] cell_take;
    logic [CMP_W-1:0]   cell_rank [RING_DEPTH];
    rmu_wr_t            cell_wr   [RING_DEPTH];

    // Step a ring pointer with wrap at the current ring size.
    function automatic logic [IDX_W-1:0] ptr_step(input logic [IDX_W-1:0] p,
                                                  input logic [CNT_W-1:0] sz);
        logic [CMP_W-1:0] inc;
        inc = CMP_W'(p) + CMP_W'(1);
        return (inc >= CMP_W'(sz)) ? '0 : IDX_W'(inc);
    endfunction

    // Handshake: the result register frees up when its beat is taken.
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign full     = (count_reg >= size_reg);
    assign app_idx  = full ? head_reg : tail_reg;

    // Ring cells.
    genvar g;
    generate
        for (g = 0; g < RING_DEPTH; g++)
        begin : g_cell
            assign cell_wr[g].take_merge = accept && found && (win_idx == IDX_W'(g));
            assign cell_wr[g].append     = accept && !found && (app_idx == IDX_W'(g));

            rmu_cell #(
                .CELL_ID (g),
                .IDX_W   (IDX_W),
                .CMP_W   (CMP_W)
            ) u_cell (
                .clk         (clk),
                .size        (size_reg),
                .head        (head_reg),
                .count       (count_reg),
                .range_first (range_first),
                .range_last  (range_last),
                .entry_flags (entry_flags),
                .merge_on    (merge_enable),
                .wr          (cell_wr[g]),
                .take        (cell_take[g]),
                .rank        (cell_rank[g])
            );
        end
    endgenerate

    // Oldest matching cell.
    rmu_pick #(
        .N     (RING_DEPTH),
        .IDX_W (IDX_W),
        .CMP_W (CMP_W)
    ) u_pick (
        .take    (cell_take),
        .rank    (cell_rank),
        .found   (found),
        .win_idx (win_idx)
    );

    // Next ring state for an accepted run or a size write.
    always_comb
    begin
        size_next  = size_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        slot_next  = found ? win_idx : app_idx;
        if (cfg_wr_en)
        begin
            if (cfg_wr_data == '0)
            begin
                size_next = CNT_W'(1);
            end
            else if (cfg_wr_data > SIZE_CAP)
            begin
                size_next = SIZE_CAP;
            end
            else
            begin
                size_next = cfg_wr_data;
            end
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end
        else if (accept && !found)
        begin
            tail_next = ptr_step(tail_reg, size_reg);
            if (full)
            begin
                head_next = ptr_step(head_reg, size_reg);
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    // Ring control and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= SIZE_RESET;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            size_reg  <= size_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result beat payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            merged_reg    <= found;
            slot_reg      <= SLOT_W'(slot_next);
            overwrote_reg <= !found && full;
            count_out_reg <= count_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign merged           = merged_reg;
    assign slot             = slot_reg;
    assign overwrote_oldest = overwrote_reg;
    assign entry_count      = count_out_reg;

`ifndef SYNTH
    // The entry count never exceeds the ring size.
    a_count_le_size: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= size_reg)
        else $error("entry count exceeds ring size");

    // Both pointers stay inside the ring.
    a_ptr_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (CMP_W'(head_reg) < CMP_W'(size_reg)) && (CMP_W'(tail_reg) < CMP_W'(size_reg)))
        else $error("ring pointer outside ring");

    // A full or empty ring has head and tail together.
    a_full_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        ((count_reg == size_reg) || (count_reg == '0)) |-> (head_reg == tail_reg))
        else $error("head and tail apart on full or empty ring");

    // A merge leaves the count and the pointers alone.
    a_merge_keeps_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && found && !cfg_wr_en) |=>
        ($stable(count_reg) && $stable(head_reg) && $stable(tail_reg)))
        else $error("merge moved the ring");
`endif

endmodule

// ===== tb/cluster_run_ring_merge_unit_tb.sv =====
// ----------------------------------------------------------------------------
// cluster_run_ring_merge_unit_tb: self-checking bench for the run ring
// Drives offered cluster runs under random idling and output stalls, keeps
// its own model of the ring, and checks every result beat against it.
// ----------------------------------------------------------------------------
module cluster_run_ring_merge_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rmu_pkg::*;

    // Cycles without any beat before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;
    // Length of the long receiver hold-off.
    localparam int HOLD_CYCLES = 80;
    // Random runs offered per ring size setting.
    localparam int RUNS_PER_SETTING = 230;

    // One expected or observed result beat.
    typedef struct packed {
        logic              merged;
        logic [SLOT_W-1:0] slot;
        logic              overwrote;
        logic [CNT_W-1:0]  count;
    } ring_beat_t;

    // A cluster run as offered on the input.
    typedef struct packed {
        logic [FIELD_W-1:0] lo;
        logic [FIELD_W-1:0] hi;
    } cluster_run_t;

    // Tracks the ring contents and the queue of result beats still owed.
    class run_ring_tracker;
        logic [FIELD_W-1:0] first_q [RING_DEPTH_DEF];
        logic [FIELD_W-1:0] last_q  [RING_DEPTH_DEF];
        int unsigned        head;
        int unsigned        tail;
        int unsigned        count;
        logic [CNT_W-1:0]   size_reg;
        ring_beat_t         owed_beats[$];
        int                 errors;

        function new();
            errors = 0;
            restart(CNT_W'(RING_SIZE_RST));
        endfunction

        // A ring size write empties the ring.
        function void restart(logic [CNT_W-1:0] size_val);
            size_reg = size_val;
            head = 0;
            tail = 0;
            count = 0;
        endfunction

        function int unsigned span();
            int unsigned s;
            s = 32'(size_reg);
            if (s == 0)
                s = 1;
            if (s > RING_DEPTH_DEF)
                s = RING_DEPTH_DEF;
            return s;
        endfunction

        function int unsigned step_index(int unsigned i, int unsigned s);
            return (i + 1 >= s) ? 0 : i + 1;
        endfunction

        function int pending();
            return owed_beats.size();
        endfunction

        // Work out the beat for an accepted run and update the ring.
        function void accept_run(logic [FIELD_W-1:0] lo, logic [FIELD_W-1:0] hi, logic mrg);
            ring_beat_t   beat;
            int unsigned  s;
            int unsigned  cur;
            int unsigned  left;
            int unsigned  pos;
            logic [FIELD_W-1:0] hi_next;
            logic         hit;

            s = span();
            if (head >= s)
                head = 0;
            if (tail >= s)
                tail = 0;
            if (count > s)
                count = s;
            beat = '0;
            hit = 1'b0;
            hi_next = hi + 32'd1;
            cur = head;

            // Oldest entry first; the run after the offered one wins over the run before it.
            if (mrg)
            begin
                left = count;
                while (left > 0 && !hit)
                begin
                    if (first_q[cur] == hi_next)
                    begin
                        first_q[cur] = lo;
                        hit = 1'b1;
                    end
                    else if (last_q[cur] + 32'd1 == lo)
                    begin
                        last_q[cur] = hi;
                        hit = 1'b1;
                    end
                    else
                    begin
                        left--;
                        cur = step_index(cur, s);
                    end
                end
            end

            if (hit)
            begin
                beat.merged = 1'b1;
                beat.slot = cur[SLOT_W-1:0];
            end
            else
            begin
                // Append, replacing the oldest entry when the ring is full.
                if (count >= s)
                begin
                    pos = head;
                    beat.overwrote = 1'b1;
                    head = step_index(head, s);
                    tail = step_index(tail, s);
                end
                else
                begin
                    pos = tail;
                    tail = step_index(tail, s);
                    count++;
                end
                first_q[pos] = lo;
                last_q[pos] = hi;
                beat.slot = pos[SLOT_W-1:0];
            end
            beat.count = count[CNT_W-1:0];
            owed_beats.push_back(beat);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        // Compare an accepted result beat with the oldest owed beat.
        function void check_beat(ring_beat_t got);
            ring_beat_t want;
            if (owed_beats.size() == 0)
            begin
                $display("%0t: result beat with none expected, expected none, actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = owed_beats.pop_front();
            compare_field("merged", 32'(want.merged), 32'(got.merged));
            compare_field("slot", 32'(want.slot), 32'(got.slot));
            compare_field("overwrote_oldest", 32'(want.overwrote), 32'(got.overwrote));
            compare_field("entry_count", 32'(want.count), 32'(got.count));
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [CNT_W-1:0]   cfg_wr_data;
    logic               in_valid;
    logic               in_stall;
    logic [FIELD_W-1:0] range_first;
    logic [FIELD_W-1:0] range_last;
    logic [FIELD_W-1:0] entry_flags;
    logic               merge_enable;
    logic               out_valid;
    logic               out_stall;
    logic               merged;
    logic [SLOT_W-1:0]  slot;
    logic               overwrote_oldest;
    logic [CNT_W-1:0]   entry_count;

    run_ring_tracker tracker = new();
    cluster_run_t    recent_runs[$];
    bit              quiet_phase = 1'b0;
    bit              hold_off_req = 1'b0;
    int              idle_cycles = 0;

    cluster_run_ring_merge_unit uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .range_first      (range_first),
        .range_last       (range_last),
        .entry_flags      (entry_flags),
        .merge_enable     (merge_enable),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .merged           (merged),
        .slot             (slot),
        .overwrote_oldest (overwrote_oldest),
        .entry_count      (entry_count)
    );

    always #10 clk = ~clk;

    // Check result beats first, then note the run accepted on the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                tracker.check_beat({merged, slot, overwrote_oldest, entry_count});
            if (in_valid && !in_stall)
                tracker.accept_run(range_first, range_last, merge_enable);
        end
    end

    // Watchdog on cycles in which no beat moves on either side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Receiver: random stalls, none in the quiet phase, and one long hold-off.
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= !quiet_phase && ($urandom_range(99) < 7);
        end
    end

    // Offer one run and hold it until the block takes it.
    task automatic send_run(logic [FIELD_W-1:0] lo, logic [FIELD_W-1:0] hi,
                            logic [FIELD_W-1:0] fl, logic mrg);
        if (!quiet_phase && $urandom_range(99) < 7)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        range_first <= lo;
        range_last <= hi;
        entry_flags <= fl;
        merge_enable <= mrg;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Stop offering and wait until every owed beat has come back.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic set_ring_size(logic [CNT_W-1:0] size_val);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= size_val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tracker.restart(size_val);
    endtask

    // Mostly runs that touch a recent run from either side, with some noise.
    task automatic send_random_runs(int n);
        int                 pick;
        cluster_run_t       near;
        cluster_run_t       run;
        logic [FIELD_W-1:0] len;
        logic               mrg;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            len = ($urandom_range(99) < 90) ? $urandom_range(15) : $urandom;
            if (recent_runs.size() == 0 || pick >= 85)
            begin
                run.lo = $urandom;
                run.hi = (pick >= 95) ? $urandom : run.lo + len;
                mrg = 1'($urandom_range(1));
            end
            else
            begin
                near = recent_runs[$urandom_range(recent_runs.size() - 1)];
                if (pick < 50)
                begin
                    run.lo = near.hi + 32'd1;
                    run.hi = run.lo + len;
                end
                else
                begin
                    run.hi = near.lo - 32'd1;
                    run.lo = run.hi - len;
                end
                mrg = (pick < 78);
            end
            send_run(run.lo, run.hi, $urandom, mrg);
            recent_runs.push_back(run);
            if (recent_runs.size() > 8)
                void'(recent_runs.pop_front());
        end
    endtask

    initial
    begin
        logic [CNT_W-1:0] sizes[8];
        sizes = '{5'd1, 5'd16, 5'd4, 5'd31, 5'd0, 5'd17, 5'd2, 5'd8};

        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        in_valid <= 1'b0;
        range_first <= '0;
        range_last <= '0;
        entry_flags <= '0;
        merge_enable <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed runs at the reset ring size.
        // Wrap: the stored run starting at zero follows the all-ones cluster.
        send_run(32'h0, 32'h0, 32'h0, 1'b0);
        send_run(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_run(32'd1, 32'd5, 32'h1234_5678, 1'b1);
        send_run(32'd10, 32'd20, 32'hA5A5_A5A5, 1'b1);
        // Both stored runs touch this one; the oldest must take it.
        send_run(32'd6, 32'd9, 32'h5A5A_5A5A, 1'b1);
        send_run(32'd21, 32'd30, 32'h0000_FFFF, 1'b0);
        // An inverted run is stored and compared as given.
        send_run(32'd100, 32'd50, 32'hFFFF_0000, 1'b1);
        send_run(32'd51, 32'd60, 32'h8000_0001, 1'b1);
        // Fill the ring and overwrite the oldest entries.
        for (int i = 0; i < 14; i++)
            send_run(32'd1000 + 32'(i) * 32'd10, 32'd1004 + 32'(i) * 32'd10, $urandom, 1'b0);
        drain();

        // Random runs under a series of ring sizes, extremes included.
        for (int p = 0; p < 8; p++)
        begin
            set_ring_size(sizes[p]);
            quiet_phase = (p == 1);
            if (p == 3)
                hold_off_req = 1'b1;
            send_random_runs(RUNS_PER_SETTING);
            quiet_phase = 1'b0;
            drain();
        end

        repeat (3) @(posedge clk);
        if (tracker.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
src/rmu_pkg.sv
src/rmu_cell.sv
src/rmu_pick.sv
src/cluster_run_ring_merge_unit.sv
tb/cluster_run_ring_merge_unit_tb.sv
